FILE: rtl/aabb_pkg.sv
`timescale 1ns / 1ps

package aabb_pkg;

	// Field widths of the box coordinates and the matrix coefficients.
	localparam int COORD_W    = 32;
	localparam int COEF_W     = 16;
	localparam int AXES       = 3;
	localparam int OFFS_W     = 32;
	localparam int ROW_W      = AXES * COEF_W;

	// A coordinate times a coefficient is exact in PROD_W bits; three of them in SUM_W.
	localparam int PROD_W     = COORD_W + COEF_W;
	localparam int SUM_W      = PROD_W + 2;

	// Rounding from Q20.28 to Q16.16: nearest, ties toward plus infinity.
	localparam int FRAC_SHIFT = 12;
	localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);

	// Stream payload width: six coordinates, already a whole number of bytes.
	localparam int BOX_W      = 2 * AXES * COORD_W;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = ROW_W;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_Z    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = 3'd5;

	// Identity coefficient, 1.0 in Q4.12.
	localparam logic [COEF_W-1:0] COEF_ONE = 16'h1000;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COEF_W-1:0]  coef_t;
	typedef logic signed [PROD_W-1:0]  prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	// Matrix rows (input axis) of packed coefficients (output axis in 16-bit slots),
	// plus the translation row.
	typedef struct packed {
		logic [AXES-1:0][ROW_W-1:0]  row;
		logic [AXES-1:0][OFFS_W-1:0] offs;
	} cfg_t;

endpackage

FILE: rtl/aabb_affine_transform_bounds_core.sv
// Channel  Direction  Ports                                   Carries
// s_axis   in         s_axis_tvalid/tready/tdata[191:0]       source box
// m_axis   out        m_axis_tvalid/tready/tdata[191:0]       transformed box
// cfg      in         cfg_valid/cfg_ready/cfg_index/cfg_data  matrix rows, translation
//
// One box is taken per cycle unless a stall on m_axis has filled every stage; its result is
// registered in turn by the multiply, term select, sum, and round and clamp stages.
// The four stages are set by the 32x16 multipliers and the 50-bit adders.
// Reset clears the valid bits of all stages and loads the identity transform.
// A stall on m_axis holds every full stage; s_axis_tready falls only once all are full.
// cfg_ready is always high; the user must make writes only while no box is in flight (not enforced).
`timescale 1ns / 1ps

module aabb_affine_transform_bounds_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// min_x, min_y, min_z, max_x, max_y, max_z (32 bits each, lowest first)
	input  logic [aabb_pkg::BOX_W-1:0]       s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z (lowest first)
	output logic [aabb_pkg::BOX_W-1:0]       m_axis_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [aabb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [aabb_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import aabb_pkg::*;

	cfg_t   cfg;
	coord_t lo [AXES];
	coord_t hi [AXES];
	logic   mul_valid;
	logic   red_ready;
	prod_t  p_lo [AXES][AXES];
	prod_t  p_hi [AXES][AXES];
	logic   red_valid;
	logic   out_ready;
	sum_t   s_min [AXES];
	sum_t   s_max [AXES];
	coord_t o_min [AXES];
	coord_t o_max [AXES];

	// Unpack the source box and pack the result.
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			lo[a] = s_axis_tdata[a*COORD_W +: COORD_W];
			hi[a] = s_axis_tdata[(a+AXES)*COORD_W +: COORD_W];
			m_axis_tdata[a*COORD_W +: COORD_W]        = o_min[a];
			m_axis_tdata[(a+AXES)*COORD_W +: COORD_W] = o_max[a];
		end
	end

	aabb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	aabb_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.lo        (lo),
		.hi        (hi),
		.cfg       (cfg),
		.out_valid (mul_valid),
		.out_ready (red_ready),
		.p_lo      (p_lo),
		.p_hi      (p_hi)
	);

	aabb_red u_red (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mul_valid),
		.in_ready  (red_ready),
		.p_lo      (p_lo),
		.p_hi      (p_hi),
		.out_valid (red_valid),
		.out_ready (out_ready),
		.s_min     (s_min),
		.s_max     (s_max)
	);

	aabb_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (red_valid),
		.in_ready  (out_ready),
		.s_min     (s_min),
		.s_max     (s_max),
		.cfg       (cfg),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.o_min     (o_min),
		.o_max     (o_max)
	);

	// The input side stalls only when the whole pipeline is full and held.
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && mul_valid && red_valid))
		else $error("input stalled while the pipeline has room");

	// The summed extremes must stay ordered.
	a_sum_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		red_valid |-> (s_min[0] <= s_max[0] && s_min[1] <= s_max[1]
			&& s_min[2] <= s_max[2]))
		else $error("summed minimum above summed maximum");

	// The delivered box is never inverted on any axis.
	a_out_x_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (o_min[0] <= o_max[0]))
		else $error("result box inverted on x");

	a_out_y_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (o_min[1] <= o_max[1]))
		else $error("result box inverted on y");

	a_out_z_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (o_min[2] <= o_max[2]))
		else $error("result box inverted on z");

endmodule

FILE: rtl/aabb_cfg.sv
`timescale 1ns / 1ps

module aabb_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [aabb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [aabb_pkg::CFG_DATA_W-1:0]    cfg_data,
	output aabb_pkg::cfg_t                     cfg
);
	import aabb_pkg::*;

	cfg_t cfg_q;

	// Writes are always taken; an index beyond the register list is dropped.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Register file, reset to the identity transform with no translation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row[0]  <= ROW_W'(COEF_ONE);
			cfg_q.row[1]  <= ROW_W'(COEF_ONE) << COEF_W;
			cfg_q.row[2]  <= ROW_W'(COEF_ONE) << (2 * COEF_W);
			cfg_q.offs    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROW_X:    cfg_q.row[0]  <= cfg_data;
				REG_ROW_Y:    cfg_q.row[1]  <= cfg_data;
				REG_ROW_Z:    cfg_q.row[2]  <= cfg_data;
				REG_OFFSET_X: cfg_q.offs[0] <= cfg_data[OFFS_W-1:0];
				REG_OFFSET_Y: cfg_q.offs[1] <= cfg_data[OFFS_W-1:0];
				REG_OFFSET_Z: cfg_q.offs[2] <= cfg_data[OFFS_W-1:0];
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: rtl/aabb_mul.sv
`timescale 1ns / 1ps

module aabb_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  aabb_pkg::coord_t              lo [aabb_pkg::AXES],
	input  aabb_pkg::coord_t              hi [aabb_pkg::AXES],
	input  aabb_pkg::cfg_t                cfg,
	output logic                          out_valid,
	input  logic                          out_ready,
	// Indexed [output axis][input axis].
	output aabb_pkg::prod_t               p_lo [aabb_pkg::AXES][aabb_pkg::AXES],
	output aabb_pkg::prod_t               p_hi [aabb_pkg::AXES][aabb_pkg::AXES]
);
	import aabb_pkg::*;

	logic  valid_s1;
	prod_t p_lo_s1 [AXES][AXES];
	prod_t p_hi_s1 [AXES][AXES];

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign p_lo      = p_lo_s1;
	assign p_hi      = p_hi_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Both bounds of every input axis times each coefficient of its matrix row.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			for (int a = 0; a < AXES; a++) begin
				for (int i = 0; i < AXES; i++) begin
					p_lo_s1[a][i] <= prod_t'(lo[i]) *
						prod_t'(coef_t'(cfg.row[i][a*COEF_W +: COEF_W]));
					p_hi_s1[a][i] <= prod_t'(hi[i]) *
						prod_t'(coef_t'(cfg.row[i][a*COEF_W +: COEF_W]));
				end
			end
		end
	end

endmodule

FILE: rtl/aabb_red.sv
`timescale 1ns / 1ps

module aabb_red (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  aabb_pkg::prod_t      p_lo [aabb_pkg::AXES][aabb_pkg::AXES],
	input  aabb_pkg::prod_t      p_hi [aabb_pkg::AXES][aabb_pkg::AXES],
	output logic                 out_valid,
	input  logic                 out_ready,
	output aabb_pkg::sum_t       s_min [aabb_pkg::AXES],
	output aabb_pkg::sum_t       s_max [aabb_pkg::AXES]
);
	import aabb_pkg::*;

	logic  valid_s2;
	logic  valid_s3;
	logic  en_s2;
	logic  en_s3;
	prod_t tmin_s2 [AXES][AXES];
	prod_t tmax_s2 [AXES][AXES];
	sum_t  smin_s3 [AXES];
	sum_t  smax_s3 [AXES];

	// Each stage moves when it is empty or the stage after it moves.
	assign en_s3     = !valid_s3 || out_ready;
	assign en_s2     = !valid_s2 || en_s3;
	assign in_ready  = en_s2;
	assign out_valid = valid_s3;
	assign s_min     = smin_s3;
	assign s_max     = smax_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s2) begin
				valid_s2 <= in_valid;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// The sum is linear, so each term reaches its extreme independently of the others.
	always_ff @(posedge clk) begin
		if (in_valid && en_s2) begin
			for (int a = 0; a < AXES; a++) begin
				for (int i = 0; i < AXES; i++) begin
					if (p_lo[a][i] < p_hi[a][i]) begin
						tmin_s2[a][i] <= p_lo[a][i];
						tmax_s2[a][i] <= p_hi[a][i];
					end else begin
						tmin_s2[a][i] <= p_hi[a][i];
						tmax_s2[a][i] <= p_lo[a][i];
					end
				end
			end
		end
	end

	// Adding up the extreme terms gives the extreme over all eight corners.
	always_ff @(posedge clk) begin
		if (valid_s2 && en_s3) begin
			for (int a = 0; a < AXES; a++) begin
				smin_s3[a] <= sum_t'(tmin_s2[a][0]) + sum_t'(tmin_s2[a][1])
					+ sum_t'(tmin_s2[a][2]);
				smax_s3[a] <= sum_t'(tmax_s2[a][0]) + sum_t'(tmax_s2[a][1])
					+ sum_t'(tmax_s2[a][2]);
			end
		end
	end

endmodule

FILE: rtl/aabb_out.sv
`timescale 1ns / 1ps

module aabb_out (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  aabb_pkg::sum_t       s_min [aabb_pkg::AXES],
	input  aabb_pkg::sum_t       s_max [aabb_pkg::AXES],
	input  aabb_pkg::cfg_t       cfg,
	output logic                 out_valid,
	input  logic                 out_ready,
	output aabb_pkg::coord_t     o_min [aabb_pkg::AXES],
	output aabb_pkg::coord_t     o_max [aabb_pkg::AXES]
);
	import aabb_pkg::*;

	localparam sum_t SAT_HI = sum_t'({1'b0, {(COORD_W-1){1'b1}}});
	localparam sum_t SAT_LO = -SAT_HI - sum_t'(1);

	logic   valid_s4;
	coord_t omin_s4 [AXES];
	coord_t omax_s4 [AXES];

	// Round to Q16.16, add the translation, clamp to the 32-bit range.
	// Every step is monotone, so it maps the extreme sums to the extreme corners.
	function automatic coord_t finish(input sum_t s, input logic [OFFS_W-1:0] off);
		sum_t r;
		sum_t t;
		r = (s + sum_t'(ROUND_HALF)) >>> FRAC_SHIFT;
		t = r + sum_t'(coord_t'(off));
		if (t > SAT_HI) begin
			return SAT_HI[COORD_W-1:0];
		end else if (t < SAT_LO) begin
			return SAT_LO[COORD_W-1:0];
		end
		return t[COORD_W-1:0];
	endfunction

	assign in_ready  = !valid_s4 || out_ready;
	assign out_valid = valid_s4;
	assign o_min     = omin_s4;
	assign o_max     = omax_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (in_ready) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			for (int a = 0; a < AXES; a++) begin
				omin_s4[a] <= finish(s_min[a], cfg.offs[a]);
				omax_s4[a] <= finish(s_max[a], cfg.offs[a]);
			end
		end
	end

endmodule
